FILE: rtl/kpot_pkg.sv
// kpot_pkg: shared constants, word types and controller/datapath bundles
// for the keyed position odometer table. No dependencies.
package kpot_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int FRAC_BITS   = 8;
    localparam int KEY_CHARS   = 4;

    localparam int KEY_W   = 8 * KEY_CHARS;
    localparam int ROUTE_W = 10;
    localparam int POS_W   = 16;
    localparam int TIME_W  = 17;
    localparam int DIST_W  = 40;
    localparam int SLOTO_W = 7;

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    // root of a sum of two squared 16 bit magnitudes
    localparam int SUM_PAIRS  = 17;
    localparam int SQ_W       = 2 * SUM_PAIRS;
    localparam int ROOT_W     = SUM_PAIRS + FRAC_BITS;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS + 1);

    typedef struct packed {
        logic [KEY_W-1:0]   vehicle_key;
        logic [ROUTE_W-1:0] route_number;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TIME_W-1:0]  time_stamp;
    } t_in_word;

    typedef struct packed {
        logic [SLOTO_W-1:0] slot;
        logic               added;
        logic               table_full;
        logic [ROUTE_W-1:0] entry_route;
        logic [DIST_W-1:0]  distance_total;
        logic [TIME_W-1:0]  time_first;
        logic [TIME_W-1:0]  time_last;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ROUTE_W-1:0] route;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [TIME_W-1:0]  t_first;
        logic [TIME_W-1:0]  t_last;
        logic [DIST_W-1:0]  odo;
    } t_entry;

    typedef struct packed {
        logic start;
        logic scan;
        logic capture;
        logic mul_x;
        logic mul_y;
        logic sqrt_start;
        logic finish_hit;
        logic finish_add;
        logic finish_full;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic cnt_zero;
        logic cnt_full;
        logic sqrt_done;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/kpot_chan_if.sv
// kpot_chan_if / kpot_res_if: valid/ready channels for report and result words.
// Depends on kpot_pkg.
interface kpot_chan_if;
    logic                                   valid;
    logic                                   ready;
    logic [kpot_pkg::KEY_W-1:0]             vehicle_key;
    logic [kpot_pkg::ROUTE_W-1:0]           route_number;
    logic signed [kpot_pkg::POS_W-1:0]      pos_x;
    logic signed [kpot_pkg::POS_W-1:0]      pos_y;
    logic [kpot_pkg::TIME_W-1:0]            time_stamp;

    modport source (output valid, vehicle_key, route_number, pos_x, pos_y, time_stamp,
                    input ready);
    modport sink   (input valid, vehicle_key, route_number, pos_x, pos_y, time_stamp,
                    output ready);
endinterface

interface kpot_res_if;
    logic                           valid;
    logic                           ready;
    logic [kpot_pkg::SLOTO_W-1:0]   slot;
    logic                           added;
    logic                           table_full;
    logic [kpot_pkg::ROUTE_W-1:0]   entry_route;
    logic [kpot_pkg::DIST_W-1:0]    distance_total;
    logic [kpot_pkg::TIME_W-1:0]    time_first;
    logic [kpot_pkg::TIME_W-1:0]    time_last;

    modport source (output valid, slot, added, table_full, entry_route, distance_total,
                    time_first, time_last, input ready);
    modport sink   (input valid, slot, added, table_full, entry_route, distance_total,
                    time_first, time_last, output ready);
endinterface

FILE: rtl/keyed_position_odometer_table.sv
// keyed_position_odometer_table: top level, joins controller and datapath
// to the report and result channels. Depends on kpot_pkg, kpot_chan_if/kpot_res_if,
// kpot_ctrl, kpot_dpath.
//
// i_in carries one position report word (key, route, x, y, time); o_out returns
// one result word per report. Both are valid/ready; a word moves when both are high.
// One report is processed at a time. The key scan reads one table entry per cycle
// from the entry memory. A new key is then appended; a known key goes through the
// x and y multiply states, the root start state, the bit-serial root, a wait for the
// root to finish and the writeback state. The next report is taken as soon as the
// previous one has been written to the result register, even if that word has not
// yet been taken. If the receiver stalls with a word still held, the block waits
// before writing the next result. Reset empties the table (entry count zero) and
// drops any held result; no memory clearing pass is needed.
module keyed_position_odometer_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kpot_chan_if.sink       i_in,
    kpot_res_if.source      o_out
);
    kpot_pkg::t_cmd      w_cmd;
    kpot_pkg::t_stat     w_stat;
    kpot_pkg::t_in_word  w_in_word;
    kpot_pkg::t_out_word w_out_word;
    logic                w_in_ready;
    logic                w_out_valid;

    assign w_in_word.vehicle_key  = i_in.vehicle_key;
    assign w_in_word.route_number = i_in.route_number;
    assign w_in_word.pos_x        = i_in.pos_x;
    assign w_in_word.pos_y        = i_in.pos_y;
    assign w_in_word.time_stamp   = i_in.time_stamp;

    kpot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    kpot_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_word      (w_in_word),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_out_word  (w_out_word)
    );

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = w_out_valid;
    assign o_out.slot           = w_out_word.slot;
    assign o_out.added          = w_out_word.added;
    assign o_out.table_full     = w_out_word.table_full;
    assign o_out.entry_route    = w_out_word.entry_route;
    assign o_out.distance_total = w_out_word.distance_total;
    assign o_out.time_first     = w_out_word.time_first;
    assign o_out.time_last      = w_out_word.time_last;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_in_ready)
        else $error("report taken while previous one in progress");

    a_no_append_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish_add |-> !w_stat.cnt_full)
        else $error("append into a full table");

    a_result_reg_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.finish_add || w_cmd.finish_hit || w_cmd.finish_full) |-> w_stat.out_free)
        else $error("result overwritten before taken");

    a_root_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sqrt_start |=> !w_stat.sqrt_done)
        else $error("root finished too early");
endmodule

FILE: rtl/kpot_sqrt.sv
// kpot_sqrt: bit-serial integer square root, one result bit per cycle,
// FRAC_BITS fraction bits. Depends on kpot_pkg.
module kpot_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kpot_pkg::SQ_W-1:0]     i_sq,
    output logic                          o_done,
    output logic [kpot_pkg::ROOT_W-1:0]   o_root
);
    localparam int SQ_W   = kpot_pkg::SQ_W;
    localparam int ROOT_W = kpot_pkg::ROOT_W;
    localparam int REM_W  = kpot_pkg::REM_W;
    localparam int STEP_W = kpot_pkg::STEP_W;

    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_ge;

    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1 -: 2]};
    assign w_trial  = REM_W'({r_root, 2'b01});
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(kpot_pkg::SQRT_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_sq;
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: rtl/kpot_dpath.sv
// kpot_dpath: entry memory, key scan, step length and odometer update,
// result register. Depends on kpot_pkg and kpot_sqrt.
module kpot_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kpot_pkg::t_cmd      i_cmd,
    input  kpot_pkg::t_in_word  i_word,
    input  logic                i_out_ready,
    output kpot_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output kpot_pkg::t_out_word o_out_word
);
    localparam int SLOT_W = kpot_pkg::SLOT_W;
    localparam int CNT_W  = kpot_pkg::CNT_W;
    localparam int POS_W  = kpot_pkg::POS_W;
    localparam int SQ_W   = kpot_pkg::SQ_W;
    localparam int DIST_W = kpot_pkg::DIST_W;

    kpot_pkg::t_entry    r_mem [kpot_pkg::TABLE_DEPTH];
    kpot_pkg::t_entry    r_rd;
    kpot_pkg::t_entry    r_ent;
    kpot_pkg::t_in_word  r_word;
    kpot_pkg::t_out_word r_out;
    logic [SLOT_W-1:0]   r_idx;
    logic [SLOT_W-1:0]   r_cmp_idx;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_rd_vld;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_vld;
    logic [POS_W-1:0]    r_ax;
    logic [POS_W-1:0]    r_ay;
    logic [SQ_W-1:0]     r_sq;

    logic [POS_W:0]        w_dx;
    logic [POS_W:0]        w_dy;
    logic [POS_W-1:0]      w_ax;
    logic [POS_W-1:0]      w_ay;
    logic [POS_W-1:0]      w_mul_op;
    logic [2*POS_W-1:0]    w_prod;
    logic                  w_sq_done;
    logic [kpot_pkg::ROOT_W-1:0] w_root;
    logic [DIST_W:0]       w_dsum;
    logic [DIST_W-1:0]     w_dist;
    logic                  w_wr;
    logic [SLOT_W-1:0]     w_wr_addr;
    kpot_pkg::t_entry      w_wr_data;
    kpot_pkg::t_entry      w_new;
    kpot_pkg::t_entry      w_upd;
    logic                  w_load;
    kpot_pkg::t_out_word   w_out_nxt;

    assign w_dx = {r_rd.x[POS_W-1], r_rd.x} - {r_word.pos_x[POS_W-1], r_word.pos_x};
    assign w_dy = {r_rd.y[POS_W-1], r_rd.y} - {r_word.pos_y[POS_W-1], r_word.pos_y};
    assign w_ax = w_dx[POS_W] ? POS_W'(~w_dx + 1'b1) : w_dx[POS_W-1:0];
    assign w_ay = w_dy[POS_W] ? POS_W'(~w_dy + 1'b1) : w_dy[POS_W-1:0];

    assign w_mul_op = i_cmd.mul_y ? r_ay : r_ax;
    assign w_prod   = {{POS_W{1'b0}}, w_mul_op} * {{POS_W{1'b0}}, w_mul_op};

    kpot_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_sq    (r_sq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // saturating odometer
    assign w_dsum = {1'b0, r_ent.odo} + (DIST_W + 1)'(w_root);
    assign w_dist = w_dsum[DIST_W] ? {DIST_W{1'b1}} : w_dsum[DIST_W-1:0];

    always_comb begin
        w_new         = '0;
        w_new.key     = r_word.vehicle_key;
        w_new.route   = r_word.route_number;
        w_new.x       = r_word.pos_x;
        w_new.y       = r_word.pos_y;
        w_new.t_first = r_word.time_stamp;
        w_upd         = r_ent;
        w_upd.x       = r_word.pos_x;
        w_upd.y       = r_word.pos_y;
        w_upd.t_last  = r_word.time_stamp;
        w_upd.odo     = w_dist;
    end

    always_comb begin
        w_out_nxt = '0;
        if (i_cmd.finish_full) begin
            w_out_nxt.table_full = 1'b1;
        end else if (i_cmd.finish_add) begin
            w_out_nxt.slot        = kpot_pkg::SLOTO_W'(r_count[SLOT_W-1:0]);
            w_out_nxt.added       = 1'b1;
            w_out_nxt.entry_route = r_word.route_number;
            w_out_nxt.time_first  = r_word.time_stamp;
        end else begin
            w_out_nxt.slot           = kpot_pkg::SLOTO_W'(r_slot);
            w_out_nxt.entry_route    = r_ent.route;
            w_out_nxt.distance_total = w_dist;
            w_out_nxt.time_first     = r_ent.t_first;
            w_out_nxt.time_last      = r_word.time_stamp;
        end
    end

    assign w_wr      = i_cmd.finish_add || i_cmd.finish_hit;
    assign w_wr_addr = i_cmd.finish_add ? r_count[SLOT_W-1:0] : r_slot;
    assign w_wr_data = i_cmd.finish_add ? w_new : w_upd;
    assign w_load    = i_cmd.finish_add || i_cmd.finish_hit || i_cmd.finish_full;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
        if (w_wr) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= 1'b1;
            end
            if (i_cmd.finish_add) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_word <= i_word;
            r_idx  <= '0;
        end else if (i_cmd.scan) begin
            r_idx     <= r_idx + SLOT_W'(1);
            r_cmp_idx <= r_idx;
        end
        if (i_cmd.capture) begin
            r_ent  <= r_rd;
            r_slot <= r_cmp_idx;
            r_ax   <= w_ax;
            r_ay   <= w_ay;
        end
        if (i_cmd.mul_x) begin
            r_sq <= SQ_W'(w_prod);
        end else if (i_cmd.mul_y) begin
            r_sq <= r_sq + SQ_W'(w_prod);
        end
        if (w_load) begin
            r_out <= w_out_nxt;
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.hit       = r_rd_vld && (r_rd.key == r_word.vehicle_key);
        o_stat.last      = r_rd_vld && (CNT_W'(r_cmp_idx) == r_count - CNT_W'(1));
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.cnt_full  = (r_count == CNT_W'(kpot_pkg::TABLE_DEPTH));
        o_stat.sqrt_done = w_sq_done;
        o_stat.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
endmodule

FILE: rtl/kpot_ctrl.sv
// kpot_ctrl: sequencer for search, append, step length and writeback.
// Depends on kpot_pkg.
module kpot_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  kpot_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output kpot_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_MISS, ST_MULX, ST_MULY, ST_SQGO, ST_SQWAIT, ST_UPD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.cnt_zero ? ST_MISS : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_stat.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MULX;
                end else if (i_stat.last) begin
                    n_state = ST_MISS;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_MISS: begin
                if (i_stat.out_free) begin
                    o_cmd.finish_full = i_stat.cnt_full;
                    o_cmd.finish_add  = !i_stat.cnt_full;
                    n_state           = ST_IDLE;
                end
            end
            ST_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = ST_MULY;
            end
            ST_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = ST_SQGO;
            end
            ST_SQGO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_SQWAIT;
            end
            ST_SQWAIT: begin
                if (i_stat.sqrt_done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (i_stat.out_free) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);
endmodule
